### hw/rtl/bsr_pkg.sv
// shared widths, command codes and controller/datapath handshake structs
package bsr_pkg;

    // field widths of the input and result words
    localparam int IDX_W   = 64;
    localparam int BYTE_W  = 8;
    localparam int SPACE_W = 16;
    localparam int PEND_W  = 7;

    // pending count saturates here
    localparam logic [PEND_W-1:0] PEND_MAX = 7'd64;

    // input command codes
    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic in_ready;
        logic drain;
        logic load_byte;
        logic load_empty;
    } t_ctrl_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic can_drain;
        logic stg_last;
    } t_dp_stat;

endpackage

### hw/rtl/bsr_ifs.sv
// valid/ready channel interfaces for input words and result words

interface bsr_in_if import bsr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [IDX_W-1:0]   stream_index;
    logic [BYTE_W-1:0]  data_byte;
    logic [SPACE_W-1:0] downstream_space;

    modport source (
        output valid, cmd, stream_index, data_byte, downstream_space,
        input  ready
    );
    modport sink (
        input  valid, cmd, stream_index, data_byte, downstream_space,
        output ready
    );
endinterface

interface bsr_out_if import bsr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              run_last;
    logic [PEND_W-1:0] pending_bytes;
    logic              stream_closed;

    modport source (
        output valid, out_byte, byte_valid, run_last, pending_bytes, stream_closed,
        input  ready
    );
    modport sink (
        input  valid, out_byte, byte_valid, run_last, pending_bytes, stream_closed,
        output ready
    );
endinterface

### hw/rtl/bsr_ram.sv
// generic single-write single-read ram with registered read data
module bsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/bsr_ctrl.sv
// sequencer: accept a word, then drain the contiguous run one byte at a time
module bsr_ctrl import bsr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_stat  i_stat,
    output t_ctrl_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_LOAD  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and command decode
    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (i_stat.out_free) begin
                    if (i_stat.can_drain) begin
                        o_cmd.drain = 1'b1;
                        n_state     = ST_LOAD;
                    end else begin
                        o_cmd.load_empty = 1'b1;
                        n_state          = ST_IDLE;
                    end
                end
            end
            ST_LOAD: begin
                o_cmd.load_byte = 1'b1;
                if (i_stat.stg_last) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_ISSUE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hw/rtl/bsr_dp.sv
// datapath: window check, byte store, held marks, stream pointers, output register
module bsr_dp import bsr_pkg::*; #(
    parameter int WINDOW = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctrl_cmd i_cmd,
    output t_dp_stat  o_stat,
    bsr_in_if.sink    i_in,
    bsr_out_if.source o_out
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);

    // stream state
    logic [WINDOW-1:0] r_held;
    logic [WINDOW-1:0] n_held;
    logic [IDX_W-1:0]  r_next_exp;
    logic [IDX_W-1:0]  n_next_exp;
    logic [SLOT_W-1:0] r_head;
    logic [SLOT_W-1:0] n_head;
    logic [PEND_W-1:0] r_pending;
    logic [PEND_W-1:0] n_pending;
    logic              r_end_known;
    logic              n_end_known;
    logic [IDX_W-1:0]  r_end_pos;
    logic [IDX_W-1:0]  n_end_pos;
    logic              r_closed;
    logic              n_closed;
    logic              r_stg_last;
    logic              n_stg_last;

    // output register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_bvalid;
    logic              r_out_last;
    logic [PEND_W-1:0] r_out_pend;
    logic              r_out_closed;

    logic              apply;
    logic [IDX_W-1:0]  offset;
    logic              at_or_after;
    logic [CNT_W-1:0]  limit;
    logic              in_window;
    logic [SLOT_W:0]   slot_sum;
    logic [SLOT_W-1:0] slot;
    logic              store;
    logic [IDX_W-1:0]  next_inc;
    logic [SLOT_W-1:0] head_inc;
    logic              close_now;
    logic [BYTE_W-1:0] rd_data;

    assign apply = i_cmd.in_ready && i_in.valid;

    // window check of the incoming index against the window head
    always_comb begin
        at_or_after = (i_in.stream_index >= r_next_exp);
        offset      = i_in.stream_index - r_next_exp;
        if (i_in.downstream_space < SPACE_W'(WINDOW)) begin
            limit = CNT_W'(i_in.downstream_space);
        end else begin
            limit = CNT_W'(WINDOW);
        end
        in_window = at_or_after && (offset[IDX_W-1:SLOT_W] == '0)
                    && (CNT_W'(offset[SLOT_W-1:0]) < limit);
        slot_sum  = {1'b0, r_head} + {1'b0, offset[SLOT_W-1:0]};
        if (slot_sum >= (SLOT_W+1)'(WINDOW)) begin
            slot = SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW));
        end else begin
            slot = SLOT_W'(slot_sum);
        end
        store = apply && (i_in.cmd == CMD_DATA) && !r_closed && in_window
                && !r_held[slot];
    end

    // head advance for one drained byte
    always_comb begin
        next_inc = r_next_exp + IDX_W'(1);
        if (r_head == SLOT_W'(WINDOW - 1)) begin
            head_inc = '0;
        end else begin
            head_inc = r_head + SLOT_W'(1);
        end
    end

    // state update: accept a word or drain one byte
    always_comb begin
        n_held      = r_held;
        n_next_exp  = r_next_exp;
        n_head      = r_head;
        n_pending   = r_pending;
        n_end_known = r_end_known;
        n_end_pos   = r_end_pos;
        n_closed    = r_closed;
        n_stg_last  = r_stg_last;
        close_now   = 1'b0;
        if (apply) begin
            if (i_in.cmd == CMD_END) begin
                n_end_known = 1'b1;
                n_end_pos   = i_in.stream_index;
            end
            if (store) begin
                n_held[slot] = 1'b1;
                if (r_pending < PEND_MAX) begin
                    n_pending = r_pending + PEND_W'(1);
                end
            end
            close_now = n_end_known && (r_next_exp >= n_end_pos);
            n_closed  = r_closed || close_now;
        end else if (i_cmd.drain) begin
            n_held[r_head] = 1'b0;
            n_head         = head_inc;
            n_next_exp     = next_inc;
            if (r_pending != '0) begin
                n_pending = r_pending - PEND_W'(1);
            end
            close_now  = r_end_known && (next_inc >= r_end_pos);
            n_closed   = r_closed || close_now;
            n_stg_last = n_closed || !r_held[head_inc];
        end
    end

    // stream state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_next_exp  <= '0;
            r_head      <= '0;
            r_pending   <= '0;
            r_end_known <= 1'b0;
            r_end_pos   <= '0;
            r_closed    <= 1'b0;
            r_stg_last  <= 1'b0;
        end else begin
            r_held      <= n_held;
            r_next_exp  <= n_next_exp;
            r_head      <= n_head;
            r_pending   <= n_pending;
            r_end_known <= n_end_known;
            r_end_pos   <= n_end_pos;
            r_closed    <= n_closed;
            r_stg_last  <= n_stg_last;
        end
    end

    // byte store
    bsr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (WINDOW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store),
        .i_waddr (slot),
        .i_wdata (i_in.data_byte),
        .i_re    (i_cmd.drain),
        .i_raddr (r_head),
        .o_rdata (rd_data)
    );

    // output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_byte || i_cmd.load_empty) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output word payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            r_out_byte   <= rd_data;
            r_out_bvalid <= 1'b1;
            r_out_last   <= r_stg_last;
            r_out_pend   <= r_pending;
            r_out_closed <= r_closed;
        end else if (i_cmd.load_empty) begin
            r_out_byte   <= '0;
            r_out_bvalid <= 1'b0;
            r_out_last   <= 1'b1;
            r_out_pend   <= r_pending;
            r_out_closed <= r_closed;
        end
    end

    assign i_in.ready          = i_cmd.in_ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.out_byte      = r_out_byte;
    assign o_out.byte_valid    = r_out_bvalid;
    assign o_out.run_last      = r_out_last;
    assign o_out.pending_bytes = r_out_pend;
    assign o_out.stream_closed = r_out_closed;

    // status to the controller
    assign o_stat.in_valid  = i_in.valid;
    assign o_stat.out_free  = !r_out_valid || o_out.ready;
    assign o_stat.can_drain = r_held[r_head] && !r_closed;
    assign o_stat.stg_last  = r_stg_last;

    // checks
    a_drain_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.drain |-> (r_held[r_head] && !r_closed))
        else $error("drain issued with empty head or closed stream");

    a_drain_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.drain |=> !r_held[$past(r_head)])
        else $error("drained slot still marked held");

    a_pend_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending == PEND_W'($countones(r_held)))
        else $error("pending count differs from held marks");

    a_load_empty_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_byte |-> !r_out_valid)
        else $error("byte loaded over an untaken output word");

    a_closed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_closed |=> r_closed)
        else $error("closed state dropped");

endmodule

### hw/rtl/byte_stream_reassembler.sv
// top level of the byte stream reassembler: sequencer plus datapath
//
// Takes bytes tagged with absolute stream indexes in any order, holds those
// that fall inside the window (next expected index, min(downstream_space,
// WINDOW) bytes long) in a WINDOW-entry ring, and delivers the contiguous
// run at the window head in stream order, one result word per byte; a word
// that releases nothing gives one result with byte_valid low. An end command
// records the end index and the stream closes once the next expected index
// reaches it. An input word is accepted and stored, then each byte it
// releases is read from the single read port of the byte store and loaded
// into the output register (an empty result when it releases none), each
// waiting while the output register holds an untaken word. Held marks are
// flip-flops cleared by reset, so no clearing pass runs after reset.
module byte_stream_reassembler import bsr_pkg::*; #(
    parameter int WINDOW = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsr_in_if.sink    i_in,
    bsr_out_if.source o_out
);

    t_ctrl_cmd w_cmd;
    t_dp_stat  w_stat;

    // sequencer
    bsr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // datapath
    bsr_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule
